// ===== rtl/tet_pkg.sv =====
// Package for the timed event track: field widths, action codes, controller
// states and the command and status structs between controller and datapath.
// No dependencies.
package tet_pkg;

   localparam int MAX_KEYS_DEF = 16;
   localparam int TIME_W       = 32;
   localparam int EVENT_W      = 16;
   localparam int INDEX_W      = 4;

   typedef enum logic [1:0] {
      ACT_UPDATE = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_REWIND = 2'd3
   } act_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD_RD,
      ST_ADD_CMP,
      ST_ADD_WR,
      ST_REM_RD,
      ST_REM_WR,
      ST_REM_FIN,
      ST_LEN_RD,
      ST_LEN_CAP,
      ST_MOD,
      ST_MOD_FIN,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      RD_PTR_M1,
      RD_PTR_P1,
      RD_LAST,
      RD_CURSOR
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       shift_up;
      logic       shift_dn;
      logic       ins_wr;
      logic       rem_fin;
      logic       len_cap;
      logic       upd_start;
      logic       mod_step;
      logic       mod_fin;
      logic       walk_adv;
      logic       rewind;
      logic       flush;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    len_zero;
      logic    full;
      logic    idx_oob;
      logic    ptr_zero;
      logic    ptr_one;
      logic    ptr_p1_lt_count;
      logic    ptr_p2_lt_count;
      logic    count_one;
      logic    cycle;
      logic    mod_last;
      logic    cursor_lt_count;
      logic    hit;
      logic    rd_gt_t;
      logic    ev_nz;
      logic    pend_valid;
      logic    out_free;
   } stat_type;

endpackage

// ===== rtl/tet_if.sv =====
// Handshake channels of the timed event track: request and response.
// Depends on tet_pkg for the field widths.
interface tet_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [tet_pkg::TIME_W-1:0]    time_value;
   logic [tet_pkg::EVENT_W-1:0]   event_id;
   logic [tet_pkg::INDEX_W-1:0]   key_index;
   modport source (output valid, action, time_value, event_id, key_index, input ready);
   modport sink (input valid, action, time_value, event_id, key_index, output ready);
endinterface

interface tet_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tet_pkg::EVENT_W-1:0]   fired_event;
   logic [tet_pkg::INDEX_W-1:0]   fired_key;
   logic                          last_of_run;
   modport source (output valid, fired_event, fired_key, last_of_run, input ready);
   modport sink (input valid, fired_event, fired_key, last_of_run, output ready);
endinterface

// ===== rtl/timed_event_track_unit.sv =====
// Top level of the timed event track: controller plus datapath.
// Depends on tet_pkg, tet_if, tet_ctrl and tet_dp.
//
//   channel   direction  fields
//   req_ch    in         action, time_value, event_id, key_index
//   rsp_ch    out        fired_event, fired_key, last_of_run
//   csr_*     in         cycle_mode (write only)
//
// One item is taken at a time. Rewind and an update at zero length end after decode.
// An add shifts larger keys up through read and compare steps before it writes the new
// key, and a remove shifts later keys down through read and write steps; both then
// reread the last key for the length, which a remove skips when the last key goes.
// An update walks the keys from the cursor, after the serial modulo in cycle mode.
// Reset is synchronous and needs no clearing pass.
// A stalled response holds the walk when a second fired key is found, and
// holds the final flush of the last fired key.
module timed_event_track_unit #(
   parameter int MAX_KEYS = tet_pkg::MAX_KEYS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tet_req_if.sink   req_ch,
   tet_rsp_if.source rsp_ch,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);
   import tet_pkg::*;

   cmd_type  cmd;
   stat_type st;

   tet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   tet_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_ch.action),
      .req_time_value  (req_ch.time_value),
      .req_event_id    (req_ch.event_id),
      .req_key_index   (req_ch.key_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .st              (st),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_fired_event (rsp_ch.fired_event),
      .rsp_fired_key   (rsp_ch.fired_key),
      .rsp_last_of_run (rsp_ch.last_of_run)
   );

   // A silent key never produces a beat.
   a_event_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.fired_event != '0)
      else $error("response beat with zero event id");

   // Every fired key of a run is handed out before a new item is taken.
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !st.pend_valid)
      else $error("pending result left when idle");

   // A non-update item never starts a run of results.
   a_edit_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.action != ACT_UPDATE) |=> ##1 !cmd.walk_adv)
      else $error("walk started by an edit");

endmodule

// ===== rtl/tet_ctrl.sv =====
// Controller state machine of the timed event track.
// Depends on tet_pkg; drives the datapath through cmd_type, reads stat_type.
module tet_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tet_pkg::stat_type st,
   output tet_pkg::cmd_type  cmd
);
   import tet_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (st.act)
               ACT_UPDATE: begin
                  if (st.len_zero) state_in = ST_IDLE;
                  else if (st.cycle) state_in = ST_MOD;
                  else state_in = ST_WALK_RD;
               end
               ACT_ADD: begin
                  if (st.full) state_in = ST_IDLE;
                  else if (st.ptr_zero) state_in = ST_ADD_WR;
                  else state_in = ST_ADD_RD;
               end
               ACT_REMOVE: begin
                  if (st.idx_oob) state_in = ST_IDLE;
                  else if (st.ptr_p1_lt_count) state_in = ST_REM_RD;
                  else state_in = ST_REM_FIN;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ADD_RD:  state_in = ST_ADD_CMP;
         ST_ADD_CMP: begin
            if (st.rd_gt_t && !st.ptr_one) state_in = ST_ADD_RD;
            else state_in = ST_ADD_WR;
         end
         ST_ADD_WR:  state_in = ST_LEN_RD;
         ST_REM_RD:  state_in = ST_REM_WR;
         ST_REM_WR: begin
            if (st.ptr_p2_lt_count) state_in = ST_REM_RD;
            else state_in = ST_REM_FIN;
         end
         ST_REM_FIN: begin
            if (st.count_one) state_in = ST_IDLE;
            else state_in = ST_LEN_RD;
         end
         ST_LEN_RD:  state_in = ST_LEN_CAP;
         ST_LEN_CAP: state_in = ST_IDLE;
         ST_MOD: begin
            if (st.mod_last) state_in = ST_MOD_FIN;
         end
         ST_MOD_FIN: state_in = ST_WALK_RD;
         ST_WALK_RD: begin
            if (st.cursor_lt_count) state_in = ST_WALK_CMP;
            else state_in = ST_FLUSH;
         end
         ST_WALK_CMP: begin
            if (!st.hit) state_in = ST_FLUSH;
            else if (!(st.ev_nz && st.pend_valid && !st.out_free)) state_in = ST_WALK_RD;
         end
         ST_FLUSH: begin
            if (!st.pend_valid || st.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_PTR_M1;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DECODE: begin
            if (st.act == ACT_UPDATE && !st.len_zero) cmd.upd_start = 1'b1;
            if (st.act == ACT_REWIND) cmd.rewind = 1'b1;
         end
         ST_ADD_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_PTR_M1;
         end
         ST_ADD_CMP: cmd.shift_up = st.rd_gt_t;
         ST_ADD_WR:  cmd.ins_wr = 1'b1;
         ST_REM_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_PTR_P1;
         end
         ST_REM_WR:  cmd.shift_dn = 1'b1;
         ST_REM_FIN: cmd.rem_fin = 1'b1;
         ST_LEN_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_LAST;
         end
         ST_LEN_CAP: cmd.len_cap = 1'b1;
         ST_MOD:     cmd.mod_step = 1'b1;
         ST_MOD_FIN: cmd.mod_fin = 1'b1;
         ST_WALK_RD: begin
            cmd.rd_en = st.cursor_lt_count;
            cmd.rd_sel = RD_CURSOR;
         end
         ST_WALK_CMP: begin
            cmd.walk_adv = st.hit && !(st.ev_nz && st.pend_valid && !st.out_free);
         end
         ST_FLUSH:   cmd.flush = st.pend_valid && st.out_free;
         default: ;
      endcase
   end

endmodule

// ===== rtl/tet_dp.sv =====
// Datapath of the timed event track: key memories, cursor and time registers,
// serial modulo, one pending result and the response register.
// Depends on tet_pkg.
module tet_dp #(
   parameter int MAX_KEYS = tet_pkg::MAX_KEYS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_action,
   input  logic [tet_pkg::TIME_W-1:0]    req_time_value,
   input  logic [tet_pkg::EVENT_W-1:0]   req_event_id,
   input  logic [tet_pkg::INDEX_W-1:0]   req_key_index,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  tet_pkg::cmd_type              cmd,
   output tet_pkg::stat_type             st,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [tet_pkg::EVENT_W-1:0]   rsp_fired_event,
   output logic [tet_pkg::INDEX_W-1:0]   rsp_fired_key,
   output logic                          rsp_last_of_run
);
   import tet_pkg::*;

   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int AW = $clog2(MAX_KEYS);

   logic [TIME_W-1:0]  times_mem  [MAX_KEYS];
   logic [EVENT_W-1:0] events_mem [MAX_KEYS];

   act_type            act_ff;
   logic [TIME_W-1:0]  t_ff, len_ff, prev_ff, local_ff, rem_ff, dvd_ff, rd_time_ff;
   logic [EVENT_W-1:0] ev_ff, rd_event_ff, pend_event_ff, out_event_ff;
   logic [INDEX_W-1:0] idx_ff, pend_key_ff, out_key_ff;
   logic [CW-1:0]      ptr_ff, count_ff, cursor_ff;
   logic [4:0]         modcnt_ff;
   logic               cycle_ff, pend_valid_ff, out_valid_ff, out_last_ff;

   logic [CW-1:0]      rd_addr;
   logic [TIME_W:0]    trial;
   logic               out_free, push_run, push_last;

   always_comb begin
      case (cmd.rd_sel)
         RD_PTR_M1: rd_addr = ptr_ff - CW'(1);
         RD_PTR_P1: rd_addr = ptr_ff + CW'(1);
         RD_LAST:   rd_addr = count_ff - CW'(1);
         RD_CURSOR: rd_addr = cursor_ff;
         default:   rd_addr = cursor_ff;
      endcase
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign push_run  = cmd.walk_adv && (rd_event_ff != '0) && pend_valid_ff;
   assign push_last = cmd.flush;
   assign trial     = {rem_ff, dvd_ff[TIME_W-1]};

   // Key memories: one read and one write port.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_time_ff  <= times_mem[rd_addr[AW-1:0]];
         rd_event_ff <= events_mem[rd_addr[AW-1:0]];
      end
      if (cmd.shift_up || cmd.shift_dn) begin
         times_mem[ptr_ff[AW-1:0]]  <= rd_time_ff;
         events_mem[ptr_ff[AW-1:0]] <= rd_event_ff;
      end else if (cmd.ins_wr) begin
         times_mem[ptr_ff[AW-1:0]]  <= t_ff;
         events_mem[ptr_ff[AW-1:0]] <= ev_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= act_type'(req_action);
         t_ff   <= req_time_value;
         ev_ff  <= req_event_id;
         idx_ff <= req_key_index;
      end
      if (cmd.upd_start) begin
         dvd_ff <= t_ff;
      end else if (cmd.mod_step) begin
         dvd_ff <= dvd_ff << 1;
      end
      if (cmd.walk_adv && rd_event_ff != '0) begin
         pend_event_ff <= rd_event_ff;
         pend_key_ff   <= INDEX_W'(cursor_ff);
      end
      if (push_run || push_last) begin
         out_event_ff <= pend_event_ff;
         out_key_ff   <= pend_key_ff;
         out_last_ff  <= push_last;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         cursor_ff     <= '0;
         ptr_ff        <= '0;
         len_ff        <= '0;
         prev_ff       <= '0;
         local_ff      <= '0;
         rem_ff        <= '0;
         modcnt_ff     <= '0;
         cycle_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) cycle_ff <= csr_wr_data;
         if (cmd.load) begin
            if (act_type'(req_action) == ACT_ADD) ptr_ff <= count_ff;
            else ptr_ff <= CW'(req_key_index);
         end
         if (cmd.shift_up) ptr_ff <= ptr_ff - CW'(1);
         if (cmd.shift_dn) ptr_ff <= ptr_ff + CW'(1);
         if (cmd.ins_wr) begin
            count_ff  <= count_ff + CW'(1);
            cursor_ff <= '0;
         end
         if (cmd.rem_fin) begin
            count_ff  <= count_ff - CW'(1);
            cursor_ff <= '0;
         end
         if (cmd.rewind) cursor_ff <= '0;
         if (cmd.len_cap) len_ff <= rd_time_ff;
         if (cmd.upd_start) begin
            if (t_ff < prev_ff) cursor_ff <= '0;
            prev_ff   <= t_ff;
            if (!cycle_ff) local_ff <= t_ff;
            rem_ff    <= '0;
            modcnt_ff <= 5'd31;
         end
         // Restoring remainder, one dividend bit per cycle.
         if (cmd.mod_step) begin
            if (trial >= {1'b0, len_ff}) rem_ff <= TIME_W'(trial - {1'b0, len_ff});
            else rem_ff <= trial[TIME_W-1:0];
            modcnt_ff <= modcnt_ff - 5'd1;
         end
         if (cmd.mod_fin) begin
            if (rem_ff < local_ff) cursor_ff <= '0;
            local_ff <= rem_ff;
         end
         if (cmd.walk_adv) begin
            cursor_ff <= cursor_ff + CW'(1);
            if (rd_event_ff != '0) pend_valid_ff <= 1'b1;
         end
         if (cmd.flush) pend_valid_ff <= 1'b0;
         if (push_run || push_last) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      st.act             = act_ff;
      st.len_zero        = (len_ff == '0);
      st.full            = (32'(count_ff) >= MAX_KEYS);
      st.idx_oob         = (32'(idx_ff) >= 32'(count_ff));
      st.ptr_zero        = (ptr_ff == '0);
      st.ptr_one         = (ptr_ff == CW'(1));
      st.ptr_p1_lt_count = (32'(ptr_ff) + 32'd1 < 32'(count_ff));
      st.ptr_p2_lt_count = (32'(ptr_ff) + 32'd2 < 32'(count_ff));
      st.count_one       = (count_ff == CW'(1));
      st.cycle           = cycle_ff;
      st.mod_last        = (modcnt_ff == '0);
      st.cursor_lt_count = (cursor_ff < count_ff);
      st.hit             = (local_ff >= rd_time_ff);
      st.rd_gt_t         = (rd_time_ff > t_ff);
      st.ev_nz           = (rd_event_ff != '0);
      st.pend_valid      = pend_valid_ff;
      st.out_free        = out_free;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_fired_event = out_event_ff;
   assign rsp_fired_key   = out_key_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
